FILE: design/pps_pkg.sv
package pps_pkg;

  // Characters that matter while the path prefix is being read.
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;

  // Results of one processed character: up to two characters for the queue.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] char0;
    logic [7:0] char1;
  } step_res_t;

endpackage

FILE: design/pps_core.sv
module pps_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           in_char_i,
  input  logic                 room_i,
  output logic                 fire_o,
  output pps_pkg::step_res_t   res_o
);

  localparam logic [3:0] PhStart    = 4'd0;
  localparam logic [3:0] PhDrive    = 4'd1;
  localparam logic [3:0] PhUnc0     = 4'd2;
  localparam logic [3:0] PhUnc1     = 4'd3;
  localparam logic [3:0] PhUnc2     = 4'd4;
  localparam logic [3:0] PhHost     = 4'd5;
  localparam logic [3:0] PhShare    = 4'd6;
  localparam logic [3:0] PhSlashes  = 4'd7;
  localparam logic [3:0] PhDot      = 4'd8;
  localparam logic [3:0] PhDotStart = 4'd9;
  localparam logic [3:0] PhCopy     = 4'd10;

  logic       vld_q, vld_d;
  logic [7:0] char_q;
  logic [3:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       accept;
  logic       is_letter;
  logic [3:0] put_phase;
  pps_pkg::step_res_t res;

  assign fire_o     = vld_q && room_i;
  assign in_stall_o = vld_q && !room_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign vld_d      = accept ? 1'b1 : (fire_o ? 1'b0 : vld_q);

  assign is_letter = (char_q >= pps_pkg::CharUpA && char_q <= pps_pkg::CharUpZ) ||
                     (char_q >= pps_pkg::CharLowA && char_q <= pps_pkg::CharLowZ);
  // After any emitted character the path is copied, unless it was the terminator.
  assign put_phase = (char_q == pps_pkg::CharNul) ? PhStart : PhCopy;

  always_comb begin
    res       = '0;
    res.char0 = char_q;
    phase_d   = phase_q;
    held_d    = held_q;
    case (phase_q)
      PhDrive: begin
        if (char_q == pps_pkg::CharColon) begin
          phase_d = PhUnc0;
        end else begin
          res.cnt   = 2'd2;
          res.char0 = held_q;
          res.char1 = char_q;
          phase_d   = put_phase;
        end
      end
      PhUnc0, PhUnc1: begin
        if (char_q == pps_pkg::CharSlash) begin
          phase_d = (phase_q == PhUnc0) ? PhUnc1 : PhUnc2;
        end else if (char_q == pps_pkg::CharDot) begin
          phase_d = PhDot;
        end else begin
          res.cnt = 2'd1;
          phase_d = put_phase;
        end
      end
      PhUnc2: begin
        if (char_q == pps_pkg::CharNul) begin
          res.cnt = 2'd1;
          phase_d = PhStart;
        end else begin
          phase_d = (char_q == pps_pkg::CharSlash) ? PhSlashes : PhHost;
        end
      end
      PhHost, PhShare: begin
        if (char_q == pps_pkg::CharNul) begin
          res.cnt = 2'd1;
          phase_d = PhStart;
        end else if (char_q == pps_pkg::CharSlash) begin
          phase_d = (phase_q == PhHost) ? PhShare : PhSlashes;
        end
      end
      PhSlashes, PhDotStart: begin
        if (char_q == pps_pkg::CharSlash && phase_q == PhSlashes) begin
          phase_d = PhSlashes;
        end else if (char_q == pps_pkg::CharDot) begin
          phase_d = PhDot;
        end else begin
          res.cnt = 2'd1;
          phase_d = put_phase;
        end
      end
      PhDot: begin
        if (char_q == pps_pkg::CharSlash) begin
          phase_d = PhDotStart;
        end else begin
          res.cnt   = 2'd2;
          res.char0 = pps_pkg::CharDot;
          res.char1 = char_q;
          phase_d   = put_phase;
        end
      end
      PhCopy: begin
        res.cnt = 2'd1;
        phase_d = put_phase;
      end
      default: begin
        if (is_letter) begin
          held_d  = char_q;
          phase_d = PhDrive;
        end else if (char_q == pps_pkg::CharSlash) begin
          phase_d = PhUnc1;
        end else if (char_q == pps_pkg::CharDot) begin
          phase_d = PhDot;
        end else begin
          res.cnt = 2'd1;
          phase_d = put_phase;
        end
      end
    endcase
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      phase_q <= PhStart;
      held_q  <= '0;
    end else begin
      vld_q <= vld_d;
      if (fire_o) begin
        phase_q <= phase_d;
        held_q  <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= in_char_i;
    end
  end

  // A terminator always ends the path and brings the phase back to the start.
  a_nul_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_o && char_q == pps_pkg::CharNul |=> phase_q == PhStart)
    else $error("terminator did not restart the path");

  // A terminator is never swallowed.
  a_nul_emitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_o && char_q == pps_pkg::CharNul |-> res.cnt != 2'd0)
    else $error("terminator dropped");

  // Only a held drive letter or dot can release two characters at once.
  a_pair_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_o && res.cnt == 2'd2 |-> phase_q == PhDrive || phase_q == PhDot)
    else $error("pair released outside a hold phase");

  // The input register is not overwritten while it still holds work.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !fire_o |=> vld_q && $stable(char_q))
    else $error("pending character lost");

endmodule

FILE: design/pps_queue.sv
module pps_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  pps_pkg::step_res_t   res_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_char_o
);

  logic [7:0] mem_q [4];
  logic [1:0] wp_q, wp_d;
  logic [1:0] rp_q, rp_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] wr_n;
  logic       rd;

  assign wr_n        = wr_i ? res_i.cnt : 2'd0;
  assign out_valid_o = cnt_q != 3'd0;
  assign out_char_o  = mem_q[rp_q];
  assign rd          = out_valid_o && !out_stall_i;
  // Room for the largest burst of one character, a pair.
  assign room_o      = cnt_q <= 3'd2;

  assign wp_d  = wp_q + wr_n;
  assign rp_d  = rp_q + {1'b0, rd};
  assign cnt_d = cnt_q + {1'b0, wr_n} - {2'b00, rd};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_n != 2'd0) begin
      mem_q[wp_q] <= res_i.char0;
    end
    if (wr_n == 2'd2) begin
      mem_q[wp_q + 2'd1] <= res_i.char1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_n != 2'd0 |-> cnt_q <= 3'd2)
    else $error("result queue overflow");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 3'd4 |-> (wp_q - rp_q) == cnt_q[1:0])
    else $error("queue pointers disagree with count");

endmodule

FILE: design/path_prefix_stripper.sv
// A character is taken into the input register, processed, and written to the result
// queue when it has room. Throughput: one character per cycle while the queue can take
// a pair; a held drive letter or dot released with the next character adds a second
// output character, absorbed by the four-entry queue.
// Reset (rst_ni, asynchronous, active low) empties the input register and the queue
// and returns the prefix state machine to the start of a path.
module path_prefix_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       out_end_of_path_o
);

  // The core holds one character in its input register. Each cycle that character
  // is run through the prefix state machine, which decides whether it is dropped,
  // held back (a possible drive letter or the dot of a "./" pair), or emitted. A
  // released hold emits two characters in the same transfer into the queue.
  logic               fire;
  logic               room;
  pps_pkg::step_res_t res;

  pps_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_char_i  (in_char_i),
    .room_i     (room),
    .fire_o     (fire),
    .res_o      (res)
  );

  // The queue decouples the two sides: new input keeps flowing while a finished
  // character waits for the downstream side, and the core only stalls when the
  // queue could not take a full pair.
  pps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (fire),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o)
  );

  // The terminator is the only zero byte in a path, so it marks the end.
  assign out_end_of_path_o = out_char_o == pps_pkg::CharNul;

endmodule

FILE: test/tb_path_prefix_stripper.sv
module tb_path_prefix_stripper;

  // The run is bounded by a cycle count far above the slowest correct run:
  // about 1000 characters, each with up to the longest input gap in front of it
  // and up to two results that may each wait out the longest output stall.
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumChars   = 950;
  localparam int unsigned DrainWait  = 100;
  localparam int unsigned MaxPrinted = 40;

  // Prefix parser phases of the predictor.
  typedef enum logic [3:0] {
    PhStart    = 4'd0,
    PhDrive    = 4'd1,
    PhUnc0     = 4'd2,
    PhUnc1     = 4'd3,
    PhUnc2     = 4'd4,
    PhHost     = 4'd5,
    PhShare    = 4'd6,
    PhSlashes  = 4'd7,
    PhDot      = 4'd8,
    PhDotStart = 4'd9,
    PhCopy     = 4'd10
  } prefix_phase_e;

  // One character that the block is expected to send out.
  typedef struct packed {
    logic [7:0] ch;
    logic       eop;
  } kept_char_t;

  logic       clk_i;
  logic       rst_ni            = 1'b0;
  logic       in_valid_i        = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_char_i         = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i       = 1'b0;
  logic [7:0] out_char_o;
  logic       out_end_of_path_o;

  path_prefix_stripper i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_char_i        (in_char_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_char_o       (out_char_o),
    .out_end_of_path_o(out_end_of_path_o)
  );

  // Characters still to be sent, and the characters the block owes us.
  logic [7:0]  pending_chars[$];
  kept_char_t  kept_chars[$];

  // Predictor state: the parser phase and the one character that may be held
  // back (a possible drive letter or the dot of a dot-slash pair).
  prefix_phase_e strip_phase = PhStart;
  logic [7:0]    held_char   = 8'h00;

  int unsigned err_cnt       = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned chars_in      = 0;
  int unsigned chars_out     = 0;
  int unsigned paths_in      = 0;
  int unsigned held_releases = 0;

  // Driver and stall bookkeeping. While a calm flag is set that side runs
  // without any idling, so that stretches at full rate appear as well.
  logic        in_took   = 1'b0;
  int unsigned in_gap    = 0;
  int unsigned stall_left = 0;
  bit          calm_in   = 1'b0;
  bit          calm_out  = 1'b0;
  kept_char_t  got_char;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Reset is released at a falling edge with a nonblocking write, so the
  // driver does not see it released at that same falling edge.
  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < MaxPrinted) begin
      $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    end
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_ascii_letter(input logic [7:0] c);
    return (c >= pps_pkg::CharUpA && c <= pps_pkg::CharUpZ) ||
           (c >= pps_pkg::CharLowA && c <= pps_pkg::CharLowZ);
  endfunction

  // A character is passed on. The terminator sends the parser back to the
  // start of a path, anything else means the prefix is over.
  function automatic void keep_char(input logic [7:0] c);
    kept_chars.push_back(kept_char_t'{ch: c, eop: (c == pps_pkg::CharNul)});
    held_char   = 8'h00;
    strip_phase = (c == pps_pkg::CharNul) ? PhStart : PhCopy;
  endfunction

  // Where dot-slash pairs may be skipped, a dot is held until the next
  // character shows whether it starts such a pair.
  function automatic void dot_or_keep(input logic [7:0] c);
    if (c == pps_pkg::CharDot) begin
      held_char   = c;
      strip_phase = PhDot;
    end else begin
      keep_char(c);
    end
  endfunction

  function automatic void strip_step(input logic [7:0] c);
    logic [7:0] first;
    case (strip_phase)
      PhDrive: begin
        if (c == pps_pkg::CharColon) begin
          held_char   = 8'h00;
          strip_phase = PhUnc0;
        end else begin
          // The letter was no drive letter: it goes out with this character.
          first = held_char;
          keep_char(first);
          keep_char(c);
          held_releases++;
        end
      end
      PhUnc0: begin
        if (c == pps_pkg::CharSlash) strip_phase = PhUnc1;
        else dot_or_keep(c);
      end
      PhUnc1: begin
        if (c == pps_pkg::CharSlash) strip_phase = PhUnc2;
        else dot_or_keep(c);
      end
      PhUnc2: begin
        // A third slash means there is no host: all slashes are dropped.
        if (c == pps_pkg::CharNul) keep_char(c);
        else strip_phase = (c == pps_pkg::CharSlash) ? PhSlashes : PhHost;
      end
      PhHost: begin
        if (c == pps_pkg::CharNul) keep_char(c);
        else if (c == pps_pkg::CharSlash) strip_phase = PhShare;
      end
      PhShare: begin
        if (c == pps_pkg::CharNul) keep_char(c);
        else if (c == pps_pkg::CharSlash) strip_phase = PhSlashes;
      end
      PhSlashes: begin
        if (c != pps_pkg::CharSlash) dot_or_keep(c);
      end
      PhDot: begin
        if (c == pps_pkg::CharSlash) begin
          held_char   = 8'h00;
          strip_phase = PhDotStart;
        end else begin
          keep_char(pps_pkg::CharDot);
          keep_char(c);
          held_releases++;
        end
      end
      PhDotStart: dot_or_keep(c);
      PhCopy:     keep_char(c);
      default: begin
        // Start of a path, and any phase value that should never occur.
        held_char = 8'h00;
        if (is_ascii_letter(c)) begin
          held_char   = c;
          strip_phase = PhDrive;
        end else if (c == pps_pkg::CharSlash) begin
          strip_phase = PhUnc1;
        end else begin
          dot_or_keep(c);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_path(input string s);
    for (int i = 0; i < s.len(); i++) begin
      pending_chars.push_back(s[i]);
    end
    pending_chars.push_back(pps_pkg::CharNul);
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return pps_pkg::CharUpA + 8'($urandom_range(0, 25));
    return pps_pkg::CharLowA + 8'($urandom_range(0, 25));
  endfunction

  // Host and share names: any byte except the slash and the terminator.
  function automatic logic [7:0] rand_name_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == pps_pkg::CharSlash) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  // Body characters lean towards the ones the parser looks at.
  function automatic logic [7:0] rand_body_char();
    case ($urandom_range(0, 7))
      0:       return rand_letter();
      1:       return pps_pkg::CharSlash;
      2:       return pps_pkg::CharDot;
      3:       return pps_pkg::CharColon;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // One random path, terminator included. Most paths are built from the
  // prefix pieces in their proper order with random content; some are pure
  // noise, and some are cut short so that the terminator lands in every
  // phase of the prefix.
  function automatic void gen_path();
    logic [7:0]  p[$];
    int unsigned kind;
    int unsigned n;
    int unsigned cut;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(0, 8);
      repeat (n) p.push_back(8'($urandom_range(1, 255)));
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          p.push_back(rand_letter());
          p.push_back(pps_pkg::CharColon);
        end
        4: p.push_back(rand_letter());
        default: ;
      endcase
      case ($urandom_range(0, 6))
        1, 2: begin
          p.push_back(pps_pkg::CharSlash);
          p.push_back(pps_pkg::CharSlash);
          repeat ($urandom_range(0, 4)) p.push_back(rand_name_char());
          p.push_back(pps_pkg::CharSlash);
          repeat ($urandom_range(0, 4)) p.push_back(rand_name_char());
          p.push_back(pps_pkg::CharSlash);
          repeat ($urandom_range(0, 2)) p.push_back(pps_pkg::CharSlash);
        end
        3: repeat ($urandom_range(1, 4)) p.push_back(pps_pkg::CharSlash);
        4: begin
          p.push_back(pps_pkg::CharSlash);
          p.push_back(pps_pkg::CharSlash);
          repeat ($urandom_range(1, 3)) p.push_back(rand_name_char());
        end
        default: ;
      endcase
      n = $urandom_range(0, 3);
      repeat (n) begin
        p.push_back(pps_pkg::CharDot);
        p.push_back(($urandom_range(0, 4) == 0) ? rand_body_char() : pps_pkg::CharSlash);
      end
      repeat ($urandom_range(0, 6)) p.push_back(rand_body_char());
      if (p.size() > 0 && $urandom_range(0, 6) == 0) begin
        cut = $urandom_range(0, p.size() - 1);
        while (p.size() > cut) void'(p.pop_back());
      end
    end
    foreach (p[i]) pending_chars.push_back(p[i]);
    pending_chars.push_back(pps_pkg::CharNul);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: a new transfer is offered at the falling edge once the
  // previous one was taken. The payload stays put while the block stalls.
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (pending_chars.size() != 0) begin
        in_valid_i <= 1'b1;
        in_char_i  <= pending_chars.pop_front();
        in_gap     <= pick_gap(calm_in);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Accepted input transfers are fed to the predictor at the rising edge.
  always @(posedge clk_i) begin
    in_took <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      strip_step(in_char_i);
      chars_in++;
      if (in_char_i == pps_pkg::CharNul) paths_in++;
    end
  end

  // Output stall: random stretches, short most of the time and long now and
  // then, none at all while the output side is calm.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (!calm_out && $urandom_range(0, 3) == 0) stall_left <= pick_gap(1'b0);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every output transfer is checked against the oldest expected
  // character, field by field.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chars_out++;
      if (kept_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected output char 0x%02h end %0b",
                                  out_char_o, out_end_of_path_o));
      end else begin
        got_char = kept_chars.pop_front();
        if (out_char_o !== got_char.ch) begin
          report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                    out_char_o, got_char.ch));
        end
        if (out_end_of_path_o !== got_char.eop) begin
          report_mismatch($sformatf("end_of_path %0b, expected %0b (char 0x%02h)",
                                    out_end_of_path_o, got_char.eop, got_char.ch));
        end
      end
    end
  end

  // Cycle counter with the timeout, and the switches between calm stretches
  // and stretches with random idling on either side.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if ($urandom_range(0, 199) == 0) calm_in <= !calm_in;
    if ($urandom_range(0, 199) == 0) calm_out <= !calm_out;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d chars still expected",
               cycle_cnt, kept_chars.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Directed paths: the empty path, a drive letter with nothing after it,
    // a letter that is no drive letter, slashes without a host, a path that
    // ends inside the host name, a dot that does not start a pair, a dot
    // that meets the terminator, and bytes above 127.
    push_path("");
    push_path("A:");
    push_path("zq");
    push_path("//");
    push_path("//h");
    push_path(".x");
    push_path("./.");
    pending_chars.push_back(8'hFF);
    pending_chars.push_back(8'h80);
    pending_chars.push_back(pps_pkg::CharNul);

    while (pending_chars.size() < NumChars) gen_path();

    // All characters sent, then everything owed received, then a short
    // wait to catch stray output transfers.
    while (pending_chars.size() != 0 || in_valid_i) @(posedge clk_i);
    while (kept_chars.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d characters in %0d paths, received %0d characters,",
             chars_in, paths_in, chars_out);
    $display("%0d of them as held characters released in pairs; %0d mismatches.",
             2 * held_releases, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: path_prefix_stripper.f
design/pps_pkg.sv
design/pps_core.sv
design/pps_queue.sv
design/path_prefix_stripper.sv
test/tb_path_prefix_stripper.sv
